// ===== hw/rtl/bmpd_pkg.sv =====
// Shared types and constants for the BMP raster pixel decoder.
// Holds the request and pixel payload structs, the depth codes and the unpack job.
// No dependencies.
package bmpd_pkg;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 13;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [CFG_IW-1:0] CFG_BPP    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RASTER = 1'b1;

    typedef enum logic [2:0] {
        DEPTH_1,
        DEPTH_2,
        DEPTH_4,
        DEPTH_8,
        DEPTH_24,
        DEPTH_NONE
    } depth_t;

    typedef struct packed {
        logic       command;
        logic [7:0] palette_index;
        logic [7:0] palette_blue;
        logic [7:0] palette_green;
        logic [7:0] palette_red;
        logic [7:0] raster_byte;
    } raster_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_in_run;
        logic        last_of_image;
    } pixel_t;

    // One raster byte's worth of pixels, handed from the control to the unpacker.
    typedef struct packed {
        depth_t      mode;
        logic [7:0]  data;
        logic [3:0]  count;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_image;
        logic [23:0] rgb;
    } job_t;

    function automatic depth_t depth_decode(input logic [4:0] bpp);
        depth_t d;
        case (bpp)
            5'd1:    d = DEPTH_1;
            5'd2:    d = DEPTH_2;
            5'd4:    d = DEPTH_4;
            5'd8:    d = DEPTH_8;
            5'd24:   d = DEPTH_24;
            default: d = DEPTH_NONE;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/bmpd_palette_ram.sv =====
// Palette memory: one write port, one read port with registered read data.
// Depends on nothing but its parameter; entries past the palette read as black.
module bmpd_palette_ram #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        we,
    input  logic [7:0]  widx,
    input  logic [23:0] wdata,
    input  logic        re,
    input  logic [7:0]  ridx,
    output logic [23:0] rdata
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [23:0] palette_mem [PALETTE_ENTRIES];
    logic [23:0] rd_data_reg;
    logic        rd_oor_reg;
    logic        w_in_range;
    logic        r_in_range;

    assign w_in_range = ({1'b0, widx} < 9'(PALETTE_ENTRIES));
    assign r_in_range = ({1'b0, ridx} < 9'(PALETTE_ENTRIES));

    // A read and a write to the same entry in one cycle return the old contents,
    // which is what the earlier raster byte must see.
    always_ff @(posedge clk)
    begin
        if (we && w_in_range)
        begin
            palette_mem[widx[AW-1:0]] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= palette_mem[ridx[AW-1:0]];
            rd_oor_reg  <= !r_in_range;
        end
    end

    assign rdata = rd_oor_reg ? 24'h000000 : rd_data_reg;

endmodule

// ===== hw/rtl/bmpd_unpack.sv =====
// Unpacker and output stage: one palette read per non-24-bit pixel; presents pixels.
// Uses bmpd_pkg types; reads data from bmpd_palette_ram in the cycle after the request.
module bmpd_unpack (
    input  logic            clk,
    input  logic            rst_n,
    input  bmpd_pkg::job_t  job,
    input  logic            job_load,
    output logic            free,
    output logic            rd_en,
    output logic [7:0]      rd_idx,
    input  logic [23:0]     rd_data,
    output logic            pixel_valid,
    input  logic            pixel_stall,
    output bmpd_pkg::pixel_t pixel
);

    logic                busy_reg, busy_next;
    bmpd_pkg::depth_t    mode_reg, mode_next;
    logic [7:0]          byte_reg, byte_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [11:0]         col_reg, col_next;
    logic [11:0]         row_reg, row_next;
    logic                loi_reg, loi_next;
    logic [23:0]         rgb_reg, rgb_next;

    logic                ov_reg, ov_next;
    logic [11:0]         ocol_reg;
    logic [11:0]         orow_reg;
    logic                olir_reg;
    logic                oloi_reg;
    logic                odirect_reg;
    logic [23:0]         orgb_reg;

    logic                issue;
    logic                last_issue;
    logic                direct;
    logic [23:0]         out_rgb;

    assign direct     = (mode_reg == bmpd_pkg::DEPTH_24);
    assign issue      = busy_reg && (!ov_reg || !pixel_stall);
    assign last_issue = issue && (cnt_reg == 4'd1);
    assign free       = !busy_reg || last_issue;
    assign rd_en      = issue && !direct;

    always_comb
    begin
        case (mode_reg)
            bmpd_pkg::DEPTH_1: rd_idx = {7'b0, byte_reg[7]};
            bmpd_pkg::DEPTH_2: rd_idx = {6'b0, byte_reg[7:6]};
            bmpd_pkg::DEPTH_4: rd_idx = {4'b0, byte_reg[7:4]};
            default:           rd_idx = byte_reg;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        mode_next = mode_reg;
        byte_next = byte_reg;
        cnt_next  = cnt_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        loi_next  = loi_reg;
        rgb_next  = rgb_reg;
        if (job_load)
        begin
            busy_next = 1'b1;
            mode_next = job.mode;
            byte_next = job.data;
            cnt_next  = job.count;
            col_next  = job.column;
            row_next  = job.row;
            loi_next  = job.last_image;
            rgb_next  = job.rgb;
        end
        else if (last_issue)
        begin
            busy_next = 1'b0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg - 4'd1;
            col_next = col_reg + 12'd1;
            case (mode_reg)
                bmpd_pkg::DEPTH_1: byte_next = byte_reg << 1;
                bmpd_pkg::DEPTH_2: byte_next = byte_reg << 2;
                bmpd_pkg::DEPTH_4: byte_next = byte_reg << 4;
                default:           byte_next = byte_reg;
            endcase
        end

        if (issue)
        begin
            ov_next = 1'b1;
        end
        else if (!pixel_stall)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        byte_reg <= byte_next;
        cnt_reg  <= cnt_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        loi_reg  <= loi_next;
        rgb_reg  <= rgb_next;
        if (issue)
        begin
            ocol_reg    <= col_reg;
            orow_reg    <= row_reg;
            olir_reg    <= (cnt_reg == 4'd1);
            oloi_reg    <= loi_reg && (cnt_reg == 4'd1);
            odirect_reg <= direct;
            orgb_reg    <= rgb_reg;
        end
    end

    assign out_rgb = odirect_reg ? orgb_reg : rd_data;

    assign pixel_valid         = ov_reg;
    assign pixel.red           = out_rgb[23:16];
    assign pixel.green         = out_rgb[15:8];
    assign pixel.blue          = out_rgb[7:0];
    assign pixel.column        = ocol_reg;
    assign pixel.row           = orow_reg;
    assign pixel.last_in_run   = olir_reg;
    assign pixel.last_of_image = oloi_reg;

`ifndef SYNTHESIS
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 4'd0))
        else $error("unpacker busy with an empty pixel count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> free)
        else $error("job loaded while the unpacker still had pixels to issue");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !issue |=> busy_reg && $stable(cnt_reg))
        else $error("unpacker lost pixels while the output was blocked");

    a_last_issue_marks_run: assert property (@(posedge clk) disable iff (!rst_n)
        last_issue |=> ov_reg && olir_reg)
        else $error("final pixel of a byte left without its run mark");

    a_image_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && oloi_reg |-> olir_reg)
        else $error("image end flagged on a pixel that does not close its byte");
`endif

endmodule

// ===== hw/rtl/bmpd_raster_ctrl.sv =====
// Configuration registers and raster position tracking for the BMP decoder.
// Uses bmpd_pkg; turns loads into palette writes and pixel bytes into unpack jobs.
module bmpd_raster_ctrl #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bmpd_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [bmpd_pkg::CFG_DW-1:0]     cfg_data,
    input  logic                            accept,
    input  bmpd_pkg::raster_t               item,
    output bmpd_pkg::job_t                  job,
    output logic                            job_load,
    output logic                            pal_we,
    output logic [7:0]                      pal_widx,
    output logic [23:0]                     pal_wdata
);

    localparam int WMAX = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
    localparam int WW   = $clog2(WMAX + 1);
    localparam int RBW  = $clog2(WMAX * 3 + 4);
    localparam int PBW  = $clog2(WMAX * 24 + 32);

    logic [4:0]     bpp_reg, bpp_next;
    logic [12:0]    width_reg, width_next;
    logic [12:0]    height_reg, height_next;
    logic [15:0]    pend_reg, pend_next;
    logic [1:0]     phase_reg, phase_next;
    logic [RBW-1:0] rbp_reg, rbp_next;
    logic [WW-1:0]  col_reg, col_next;
    logic [11:0]    row_reg, row_next;

    bmpd_pkg::depth_t mode;
    logic [WW-1:0]  w;
    logic [11:0]    h_last;
    logic [PBW-1:0] pw;
    logic [PBW-1:0] pbits;
    logic [PBW-1:0] words;
    logic [RBW:0]   padded;
    logic [RBW:0]   rbp_inc;
    logic           row_end;
    logic           col_lt_w;
    logic [WW-1:0]  remaining;
    logic [3:0]     per;
    logic [3:0]     cnt;
    logic [WW-1:0]  col_adv;
    logic           is_raster;

    always_comb
    begin
        mode = bmpd_pkg::depth_decode(bpp_reg);

        if (width_reg == '0)
        begin
            w = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w = WW'(WMAX);
        end
        else
        begin
            w = WW'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_last = 12'd0;
        end
        else if (int'(height_reg) > bmpd_pkg::HEIGHT_LIMIT)
        begin
            h_last = 12'(bmpd_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            h_last = 12'(height_reg - 13'd1);
        end

        // Row length in bits, rounded up to whole 32-bit words.
        pw = PBW'(w);
        case (mode)
            bmpd_pkg::DEPTH_1: pbits = pw;
            bmpd_pkg::DEPTH_2: pbits = pw << 1;
            bmpd_pkg::DEPTH_4: pbits = pw << 2;
            bmpd_pkg::DEPTH_8: pbits = pw << 3;
            default:           pbits = (pw << 4) + (pw << 3);
        endcase
        words   = (pbits + PBW'(31)) >> 5;
        padded  = (RBW + 1)'({words, 2'b00});
        rbp_inc = {1'b0, rbp_reg} + (RBW + 1)'(1);
        row_end = (rbp_inc >= padded);

        col_lt_w  = (col_reg < w);
        remaining = w - col_reg;
        case (mode)
            bmpd_pkg::DEPTH_1: per = 4'd8;
            bmpd_pkg::DEPTH_2: per = 4'd4;
            bmpd_pkg::DEPTH_4: per = 4'd2;
            default:           per = 4'd1;
        endcase
        cnt     = (remaining < WW'(per)) ? 4'(remaining) : per;
        col_adv = col_reg + WW'(cnt);
    end

    assign is_raster = accept && (item.command == bmpd_pkg::CMD_RASTER)
                       && (mode != bmpd_pkg::DEPTH_NONE);

    assign job.mode       = mode;
    assign job.data       = item.raster_byte;
    assign job.count      = cnt;
    assign job.column     = 12'(col_reg);
    assign job.row        = row_reg;
    assign job.last_image = (col_adv == w) && (row_reg == h_last);
    assign job.rgb        = {item.raster_byte, pend_reg[15:8], pend_reg[7:0]};

    assign pal_we    = accept && (item.command == bmpd_pkg::CMD_LOAD);
    assign pal_widx  = item.palette_index;
    assign pal_wdata = {item.palette_red, item.palette_green, item.palette_blue};

    always_comb
    begin
        bpp_next    = bpp_reg;
        width_next  = width_reg;
        height_next = height_reg;
        pend_next   = pend_reg;
        phase_next  = phase_reg;
        rbp_next    = rbp_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        job_load    = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                bmpd_pkg::CFG_BPP:    bpp_next    = cfg_data[4:0];
                bmpd_pkg::CFG_WIDTH:  width_next  = cfg_data;
                bmpd_pkg::CFG_HEIGHT: height_next = cfg_data;
                default:              ;
            endcase
            if (cfg_index == bmpd_pkg::CFG_BPP || cfg_index == bmpd_pkg::CFG_WIDTH
                || cfg_index == bmpd_pkg::CFG_HEIGHT)
            begin
                pend_next  = '0;
                phase_next = '0;
                rbp_next   = '0;
                col_next   = '0;
                row_next   = '0;
            end
        end
        else if (is_raster)
        begin
            if (col_lt_w)
            begin
                if (mode == bmpd_pkg::DEPTH_24)
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            pend_next  = {8'h00, item.raster_byte};
                            phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            pend_next  = {item.raster_byte, pend_reg[7:0]};
                            phase_next = 2'd2;
                        end
                        default:
                        begin
                            phase_next = 2'd0;
                            job_load   = 1'b1;
                            col_next   = col_adv;
                        end
                    endcase
                end
                else
                begin
                    job_load = 1'b1;
                    col_next = col_adv;
                end
            end

            if (row_end)
            begin
                rbp_next   = '0;
                col_next   = '0;
                phase_next = '0;
                pend_next  = '0;
                row_next   = (row_reg == h_last) ? 12'd0 : row_reg + 12'd1;
            end
            else
            begin
                rbp_next = rbp_inc[RBW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= 5'd24;
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            pend_reg   <= '0;
            phase_reg  <= '0;
            rbp_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            bpp_reg    <= bpp_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            pend_reg   <= pend_next;
            phase_reg  <= phase_next;
            rbp_reg    <= rbp_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ===== hw/rtl/bmp_raster_pixel_decoder.sv =====
// Top level of the BMP raster pixel decoder.
// Depends on bmpd_pkg, bmpd_raster_ctrl, bmpd_unpack and bmpd_palette_ram.

// Requests either load one palette entry or deliver one raster byte; pixels
// appear once the unpacker has registered the job and the output stage has
// registered the pixel and any palette read. Palette loads, 8-bit bytes and
// 24-bit bytes are accepted one per cycle while pixel_stall is low (a 24-bit
// pixel comes out with its third byte). At 1, 2 or 4 bits per pixel a byte
// yields up to 8, 4 or 2 pixels and occupies the unpacker until each is read,
// since the palette memory has one read port and delivers one entry per cycle;
// the next request is taken in the cycle the last of those pixels is read.
// Padding bytes and unsupported depths are consumed with no output. A
// configuration write restarts the raster at row 0 but keeps the palette, which
// holds no defined contents until it is loaded; no clearing pass runs after reset.
module bmp_raster_pixel_decoder #(
    parameter int MAX_WIDTH       = 4096,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bmpd_pkg::CFG_IW-1:0] cfg_index,
    input  logic [bmpd_pkg::CFG_DW-1:0] cfg_data,
    input  logic                        raster_valid,
    output logic                        raster_stall,
    input  bmpd_pkg::raster_t           raster,
    output logic                        pixel_valid,
    input  logic                        pixel_stall,
    output bmpd_pkg::pixel_t            pixel
);

    logic            accept;
    logic            unpack_free;
    bmpd_pkg::job_t  job;
    logic            job_load;
    logic            pal_we;
    logic [7:0]      pal_widx;
    logic [23:0]     pal_wdata;
    logic            rd_en;
    logic [7:0]      rd_idx;
    logic [23:0]     rd_data;

    // Loads wait for the unpacker as well, so a byte never sees a palette entry
    // written after it.
    assign raster_stall = !unpack_free;
    assign accept       = raster_valid && unpack_free;

    bmpd_raster_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (raster),
        .job       (job),
        .job_load  (job_load),
        .pal_we    (pal_we),
        .pal_widx  (pal_widx),
        .pal_wdata (pal_wdata)
    );

    bmpd_palette_ram #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .widx  (pal_widx),
        .wdata (pal_wdata),
        .re    (rd_en),
        .ridx  (rd_idx),
        .rdata (rd_data)
    );

    bmpd_unpack u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .job_load    (job_load),
        .free        (unpack_free),
        .rd_en       (rd_en),
        .rd_idx      (rd_idx),
        .rd_data     (rd_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

endmodule
